FILE: rtl/core/ahp_pkg.sv
// ----------------------------------------------------------------------------
// ahp_pkg: shared widths and register indexes for the altitude hold PID
// Field widths, accumulator sizing and configuration register codes.
// ----------------------------------------------------------------------------
package ahp_pkg;

    localparam int TGT_W    = 14;
    localparam int MEAS_W   = 17;
    localparam int VEL_W    = 16;
    localparam int DT_W     = 16;
    localparam int TOG_W    = 8;
    localparam int GAIN_W   = 16;
    localparam int THR_W    = 16;
    localparam int ERR_W    = 18;
    localparam int INT_W    = 29;
    localparam int PROD_W   = ERR_W + DT_W;
    localparam int ISUM_W   = PROD_W + 2;
    localparam int ACC_W    = 52;
    localparam int FRAC_SH  = 16;
    localparam int RND_SH   = 25;
    localparam int Q_W      = ACC_W - RND_SH;
    localparam int CNT_W    = $clog2(GAIN_W);

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 16;
    localparam int M_USER_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_P_GAIN   = 3'd0,
        REG_I_GAIN   = 3'd1,
        REG_D_GAIN   = 3'd2,
        REG_DEADBAND = 3'd3,
        REG_HOVER    = 3'd4,
        REG_INT_LIM  = 3'd5
    } cfg_reg_t;

    localparam logic [GAIN_W-1:0]       P_GAIN_RST   = 16'd16777;
    localparam logic [GAIN_W-1:0]       I_GAIN_RST   = 16'd3355;
    localparam logic [GAIN_W-1:0]       D_GAIN_RST   = 16'd13422;
    localparam logic [GAIN_W-1:0]       DEADBAND_RST = 16'd100;
    localparam logic signed [THR_W-1:0] HOVER_RST    = 16'sd10682;
    localparam logic [GAIN_W-1:0]       INT_LIM_RST  = 16'd2000;

    localparam logic signed [THR_W-1:0] THR_MAX = 16'sh7FFF;
    localparam logic signed [THR_W-1:0] THR_MIN = -16'sh8000;

endpackage

FILE: rtl/core/altitude_hold_pid.sv
// ----------------------------------------------------------------------------
// altitude_hold_pid: altitude hold PID controller with deadband and clamp
// Bit-serial shift-add datapath computing err*dt, the clamped integral and
// the P + I - D sum, rounded and saturated to a Q1.15 throttle.
// ----------------------------------------------------------------------------
//  channel   ports                        contents
//  input     s_tvalid/s_tready/s_tdata    target, measured, velocity, dt, toggle
//  result    m_tvalid/m_tready/m_tdata    throttle; m_tuser = enabled, deadband
//  config    cfg_we/cfg_index/cfg_wdata   gains, deadband, hover, integral limit
//
//  Disabled or deadband ticks pass from accept through ST_EVAL and ST_PUSH to the result.
//  Active ticks run four 16-step shift-add multiplies on one adder.
//  One transaction in flight; the next is taken once the result is registered.
//  Reset loads default registers, clears the integral, enable and toggle.
//  A stalled result holds in the output register while the next input is taken.
// ----------------------------------------------------------------------------
module altitude_hold_pid
    import ahp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [13:0] target_altitude, [30:14] measured_altitude, [46:31] vertical_velocity,
    // [62:47] step_time, [70:63] toggle_count, [71] zero
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] throttle
    output logic [M_DATA_W-1:0]   m_tdata,
    // [0] enabled, [1] in_deadband
    output logic [M_USER_W-1:0]   m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_EVAL, ST_MUL_DT, ST_INTEG, ST_MUL_P, ST_MUL_I, ST_MUL_D, ST_ROUND,
        ST_PUSH
    } state_t;

    state_t state_reg;

    logic [GAIN_W-1:0]       p_gain_reg, i_gain_reg, d_gain_reg, deadband_reg, int_lim_reg;
    logic signed [THR_W-1:0] hover_reg;

    logic [TGT_W-1:0]         tgt_reg;
    logic signed [MEAS_W-1:0] meas_reg;
    logic signed [VEL_W-1:0]  vel_reg;
    logic [DT_W-1:0]          dt_reg;
    logic [TOG_W-1:0]         last_tog_reg;
    logic                     enable_reg;
    logic signed [INT_W-1:0]  integ_reg;

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  mcand_reg;
    logic [GAIN_W-1:0]        mplier_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     sub_reg;

    logic signed [THR_W-1:0]  res_thr_reg;
    logic                     res_en_reg, res_db_reg;
    logic                     m_tvalid_reg;
    logic [M_DATA_W-1:0]      m_tdata_reg;
    logic [M_USER_W-1:0]      m_tuser_reg;

    logic                     s_fire;
    logic [TOG_W-1:0]         s_tog;
    logic signed [ERR_W-1:0]  err;
    logic [ERR_W-1:0]         mag;
    logic                     in_db;
    logic signed [ACC_W-1:0]  addend;
    logic                     mul_last;
    logic signed [ISUM_W-1:0] isum;
    logic [INT_W-1:0]         lim;
    logic signed [ISUM_W-1:0] lim_pos, lim_neg;
    logic signed [INT_W-1:0]  integ_clamped;
    logic signed [ACC_W-1:0]  rsum;
    logic signed [Q_W-1:0]    q;
    logic signed [THR_W-1:0]  q_sat;
    logic                     out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign s_tog    = s_tdata[70:63];
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        err = $signed({{(ERR_W-TGT_W){1'b0}}, tgt_reg})
            - $signed({{(ERR_W-MEAS_W){meas_reg[MEAS_W-1]}}, meas_reg});
        mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        in_db = mag < {{(ERR_W-GAIN_W){1'b0}}, deadband_reg};

        addend   = mplier_reg[0] ? (sub_reg ? -mcand_reg : mcand_reg) : '0;
        mul_last = (cnt_reg == CNT_W'(GAIN_W - 1));

        isum = $signed({{(ISUM_W-INT_W){integ_reg[INT_W-1]}}, integ_reg})
             + $signed({{(ISUM_W-PROD_W){acc_reg[PROD_W-1]}}, acc_reg[PROD_W-1:0]});
        lim = (int_lim_reg[15:12] != '0) ? {1'b0, {(INT_W-1){1'b1}}}
                                         : {1'b0, int_lim_reg[11:0], {FRAC_SH{1'b0}}};
        lim_pos = $signed({{(ISUM_W-INT_W){1'b0}}, lim});
        lim_neg = -lim_pos;
        if (isum > lim_pos) begin
            integ_clamped = INT_W'(lim_pos);
        end else if (isum < lim_neg) begin
            integ_clamped = INT_W'(lim_neg);
        end else begin
            integ_clamped = INT_W'(isum);
        end

        rsum = acc_reg + (ACC_W'(1) <<< (RND_SH - 1));
        q    = rsum[ACC_W-1:RND_SH];
        if (q > Q_W'(THR_MAX)) begin
            q_sat = THR_MAX;
        end else if (q < Q_W'(THR_MIN)) begin
            q_sat = THR_MIN;
        end else begin
            q_sat = THR_W'(q);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            p_gain_reg   <= P_GAIN_RST;
            i_gain_reg   <= I_GAIN_RST;
            d_gain_reg   <= D_GAIN_RST;
            deadband_reg <= DEADBAND_RST;
            hover_reg    <= HOVER_RST;
            int_lim_reg  <= INT_LIM_RST;
            last_tog_reg <= '0;
            enable_reg   <= 1'b0;
            integ_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_P_GAIN:   p_gain_reg   <= cfg_wdata;
                    REG_I_GAIN:   i_gain_reg   <= cfg_wdata;
                    REG_D_GAIN:   d_gain_reg   <= cfg_wdata;
                    REG_DEADBAND: deadband_reg <= cfg_wdata;
                    REG_HOVER:    hover_reg    <= $signed(cfg_wdata);
                    REG_INT_LIM:  int_lim_reg  <= cfg_wdata;
                    default: ;
                endcase
            end

            if (state_reg == ST_PUSH && out_free) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= res_thr_reg;
                m_tuser_reg  <= {res_db_reg, res_en_reg};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        tgt_reg      <= s_tdata[13:0];
                        meas_reg     <= $signed(s_tdata[30:14]);
                        vel_reg      <= $signed(s_tdata[46:31]);
                        dt_reg       <= s_tdata[62:47];
                        last_tog_reg <= s_tog;
                        if (s_tog != last_tog_reg) begin
                            enable_reg <= !enable_reg;
                        end
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (!enable_reg) begin
                        res_thr_reg <= '0;
                        res_en_reg  <= 1'b0;
                        res_db_reg  <= 1'b0;
                        state_reg   <= ST_PUSH;
                    end else if (in_db) begin
                        res_thr_reg <= hover_reg;
                        res_en_reg  <= 1'b1;
                        res_db_reg  <= 1'b1;
                        state_reg   <= ST_PUSH;
                    end else begin
                        acc_reg    <= '0;
                        mcand_reg  <= ACC_W'(err);
                        mplier_reg <= dt_reg;
                        sub_reg    <= 1'b0;
                        cnt_reg    <= '0;
                        state_reg  <= ST_MUL_DT;
                    end
                end
                ST_MUL_DT, ST_MUL_P, ST_MUL_I, ST_MUL_D: begin
                    acc_reg <= acc_reg + addend;
                    if (mul_last) begin
                        cnt_reg <= '0;
                        case (state_reg)
                            ST_MUL_DT: begin
                                state_reg <= ST_INTEG;
                            end
                            ST_MUL_P: begin
                                mcand_reg  <= ACC_W'(integ_reg);
                                mplier_reg <= i_gain_reg;
                                state_reg  <= ST_MUL_I;
                            end
                            ST_MUL_I: begin
                                mcand_reg  <= ACC_W'(vel_reg) <<< FRAC_SH;
                                mplier_reg <= d_gain_reg;
                                sub_reg    <= 1'b1;
                                state_reg  <= ST_MUL_D;
                            end
                            default: begin
                                state_reg <= ST_ROUND;
                            end
                        endcase
                    end else begin
                        mcand_reg  <= mcand_reg <<< 1;
                        mplier_reg <= mplier_reg >> 1;
                        cnt_reg    <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_INTEG: begin
                    integ_reg  <= integ_clamped;
                    acc_reg    <= '0;
                    mcand_reg  <= ACC_W'(err) <<< FRAC_SH;
                    mplier_reg <= p_gain_reg;
                    state_reg  <= ST_MUL_P;
                end
                ST_ROUND: begin
                    res_thr_reg <= q_sat;
                    res_en_reg  <= 1'b1;
                    res_db_reg  <= 1'b0;
                    state_reg   <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: rtl/core/ahp_checker.sv
// ----------------------------------------------------------------------------
// ahp_checker: port-level checks for the altitude hold PID
// Watches the input handshake and the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module ahp_checker
    import ahp_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata,
    input logic [M_USER_W-1:0]   m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_db_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("deadband flagged while disabled");

    a_off_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("nonzero throttle while disabled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not idle after reset");

    a_no_new_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !(m_tvalid && !$past(m_tvalid) && $past(aresetn)))
        else $error("result appeared one cycle after accept");

endmodule

bind altitude_hold_pid ahp_checker u_ahp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
